[rtl/qlc_pkg.sv]
// Package for the quad load cell ADC serial reader: types, constants, helpers.
package qlc_pkg;

  // Number of converter lanes carried by the ports
  localparam int unsigned LANES = 4;
  // Number of populated converters; lanes at or above this are ignored
  localparam int unsigned CHIPS = 4;
  localparam int unsigned WORD_W = 24;
  localparam int unsigned CNT_W = 5;

  // Clock pulses that carry data bits
  localparam logic [CNT_W-1:0] DATA_PULSES = CNT_W'(WORD_W);

  // Lanes taking part in the ready check and in sampling
  localparam logic [LANES-1:0] ACTIVE_MASK =
    (CHIPS >= LANES) ? {LANES{1'b1}} : LANES'((1 << CHIPS) - 1);

  // Gain select codes
  localparam logic [1:0] GAIN_128  = 2'd0;
  localparam logic [1:0] GAIN_64   = 2'd1;
  localparam logic [1:0] GAIN_32   = 2'd2;
  localparam logic [1:0] GAIN_RSVD = 2'd3;

  // Read sequencer phase, one-hot
  typedef enum logic [2:0] {
    PH_IDLE  = 3'b001,
    PH_WAIT  = 3'b010,
    PH_SHIFT = 3'b100
  } phase_t;

  typedef logic [WORD_W-1:0] word_t;

  // What one tick produces
  typedef struct packed {
    logic                    clock_out;
    logic                    busy_res;
    logic                    result_valid;
    logic [LANES-1:0][WORD_W-1:0] values;
  } tick_res_t;

  // Extra pulses after the data bits select the next channel/gain
  function automatic logic [CNT_W-1:0] extra_pulses(input logic [1:0] gain);
    logic [CNT_W-1:0] n;
    unique case (gain)
      GAIN_64:  n = CNT_W'(3);
      GAIN_32:  n = CNT_W'(2);
      default:  n = CNT_W'(1);
    endcase
    return n;
  endfunction

endpackage

[rtl/qlc_in_if.sv]
// Channel interfaces: tick input, tick result and gain configuration.
interface qlc_in_if;
  logic                         valid;
  logic                         ready;
  logic                         read_request;
  logic [qlc_pkg::LANES-1:0]    dout_lines;

  modport source (output valid, output read_request, output dout_lines, input ready);
  modport sink   (input valid, input read_request, input dout_lines, output ready);
endinterface

interface qlc_out_if;
  logic                         valid;
  logic                         ready;
  logic                         clock_out;
  logic                         busy_res;
  logic                         result_valid;
  logic [qlc_pkg::WORD_W-1:0]   value_chip0;
  logic [qlc_pkg::WORD_W-1:0]   value_chip1;
  logic [qlc_pkg::WORD_W-1:0]   value_chip2;
  logic [qlc_pkg::WORD_W-1:0]   value_chip3;

  modport source (output valid, output clock_out, output busy_res, output result_valid,
                  output value_chip0, output value_chip1, output value_chip2,
                  output value_chip3, input ready);
  modport sink   (input valid, input clock_out, input busy_res, input result_valid,
                  input value_chip0, input value_chip1, input value_chip2,
                  input value_chip3, output ready);
endinterface

interface qlc_cfg_if;
  logic       valid;
  logic       ready;
  logic [1:0] gain_select;

  modport source (output valid, output gain_select, input ready);
  modport sink   (input valid, input gain_select, output ready);
endinterface

[rtl/quad_load_cell_adc_serial_reader_core.sv]
// Top level of the quad load cell ADC serial reader.
// Each request on the input channel is one half-period tick of the shared serial
// clock and yields exactly one result request carrying the clock level to drive,
// the busy flag, a completion flag and the last delivered word of every converter
// (top bit inverted, offset binary). A read starts on a tick with read_request
// while idle, waits until every data line is low, then runs 24 data pulses and
// 1 to 3 gain pulses; a full read spans 2 * (24 + extra) ticks plus the request
// tick and the wait ticks, the last of which sees all lines low.
// The block takes one tick per clock cycle while its output register is free or
// being drained; a result is registered in the cycle after its tick is accepted
// and sits in a single output register, refilled in the same cycle it is taken.
// gain_select is written over the cfg channel, always ready; code 3 is ignored.
module quad_load_cell_adc_serial_reader_core (
  input  logic         clk,
  input  logic         rst_n,
  qlc_in_if.sink       in_ch,
  qlc_out_if.source    out_ch,
  qlc_cfg_if.sink      cfg_ch
);

  logic               gain_we;
  logic [1:0]         gain_sel_r;
  logic               in_acc;
  logic               out_vld_r;
  qlc_pkg::tick_res_t res;
  qlc_pkg::tick_res_t res_r;

  // Gain register; reserved code keeps the old value
  assign cfg_ch.ready = 1'b1;
  assign gain_we      = cfg_ch.valid && (cfg_ch.gain_select != qlc_pkg::GAIN_RSVD);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gain_sel_r <= qlc_pkg::GAIN_128;
    end else if (gain_we) begin
      gain_sel_r <= cfg_ch.gain_select;
    end
  end

  // Accept a tick whenever the output register is free or being drained
  assign in_ch.ready = !out_vld_r || out_ch.ready;
  assign in_acc      = in_ch.valid && in_ch.ready;

  qlc_seq u_seq (
    .clk          (clk),
    .rst_n        (rst_n),
    .tick_en      (in_acc),
    .read_request (in_ch.read_request),
    .dout_lines   (in_ch.dout_lines),
    .gain_select  (gain_sel_r),
    .res          (res)
  );

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (in_acc) begin
      out_vld_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      res_r <= res;
    end
  end

  assign out_ch.valid        = out_vld_r;
  assign out_ch.clock_out    = res_r.clock_out;
  assign out_ch.busy_res     = res_r.busy_res;
  assign out_ch.result_valid = res_r.result_valid;
  assign out_ch.value_chip0  = res_r.values[0];
  assign out_ch.value_chip1  = res_r.values[1];
  assign out_ch.value_chip2  = res_r.values[2];
  assign out_ch.value_chip3  = res_r.values[3];

endmodule

[rtl/qlc_seq.sv]
// Read sequencer: phase, pulse counter, clock level, shift and held words.
module qlc_seq (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       tick_en,
  input  logic                       read_request,
  input  logic [qlc_pkg::LANES-1:0]  dout_lines,
  input  logic [1:0]                 gain_select,
  output qlc_pkg::tick_res_t         res
);

  qlc_pkg::phase_t                  phase_r, phase_nxt;
  logic [qlc_pkg::CNT_W-1:0]        cnt_r, cnt_nxt;
  logic [qlc_pkg::CNT_W-1:0]        cnt_inc;
  logic                             clk_lvl_r, clk_lvl_nxt;
  qlc_pkg::word_t [qlc_pkg::LANES-1:0] shift_r, shift_nxt;
  qlc_pkg::word_t [qlc_pkg::LANES-1:0] held_r, held_nxt;
  logic [qlc_pkg::LANES-1:0]        bits;

  assign bits    = dout_lines & qlc_pkg::ACTIVE_MASK;
  assign cnt_inc = cnt_r + qlc_pkg::CNT_W'(1);

  // Next state and tick outputs
  always_comb begin
    phase_nxt        = phase_r;
    cnt_nxt          = cnt_r;
    clk_lvl_nxt      = clk_lvl_r;
    shift_nxt        = shift_r;
    held_nxt         = held_r;
    res.clock_out    = 1'b0;
    res.busy_res     = 1'b0;
    res.result_valid = 1'b0;
    unique case (phase_r)
      qlc_pkg::PH_IDLE: begin
        if (read_request) begin
          phase_nxt    = qlc_pkg::PH_WAIT;
          res.busy_res = 1'b1;
        end
      end
      qlc_pkg::PH_WAIT: begin
        res.busy_res = 1'b1;
        // all converters signal data ready by pulling low
        if (bits == '0) begin
          phase_nxt   = qlc_pkg::PH_SHIFT;
          cnt_nxt     = '0;
          clk_lvl_nxt = 1'b0;
          shift_nxt   = '0;
        end
      end
      qlc_pkg::PH_SHIFT: begin
        res.busy_res = 1'b1;
        if (!clk_lvl_r) begin
          // high tick: sample MSB first while data pulses remain
          res.clock_out = 1'b1;
          clk_lvl_nxt   = 1'b1;
          if (cnt_r < qlc_pkg::DATA_PULSES) begin
            for (int k = 0; k < int'(qlc_pkg::LANES); k++) begin
              shift_nxt[k] = {shift_r[k][qlc_pkg::WORD_W-2:0], bits[k]};
            end
          end
        end else begin
          // low tick: count the pulse, finish after the gain pulses
          clk_lvl_nxt = 1'b0;
          cnt_nxt     = cnt_inc;
          if (cnt_inc >= qlc_pkg::DATA_PULSES + qlc_pkg::extra_pulses(gain_select)) begin
            for (int k = 0; k < int'(qlc_pkg::LANES); k++) begin
              held_nxt[k] = qlc_pkg::ACTIVE_MASK[k]
                ? {~shift_r[k][qlc_pkg::WORD_W-1], shift_r[k][qlc_pkg::WORD_W-2:0]}
                : '0;
            end
            res.result_valid = 1'b1;
            phase_nxt        = qlc_pkg::PH_IDLE;
            cnt_nxt          = '0;
          end
        end
      end
      default: begin
        phase_nxt = qlc_pkg::PH_IDLE;
      end
    endcase
    res.values = held_nxt;
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= qlc_pkg::PH_IDLE;
      cnt_r     <= '0;
      clk_lvl_r <= 1'b0;
      held_r    <= '0;
    end else if (tick_en) begin
      phase_r   <= phase_nxt;
      cnt_r     <= cnt_nxt;
      clk_lvl_r <= clk_lvl_nxt;
      held_r    <= held_nxt;
    end
  end

  // Shift words are cleared on entry to the shift phase
  always_ff @(posedge clk) begin
    if (tick_en) begin
      shift_r <= shift_nxt;
    end
  end

endmodule

[tb/quad_load_cell_adc_serial_reader_core_test.sv]
// Self-checking testbench for the quad load cell ADC serial reader core.
module quad_load_cell_adc_serial_reader_core_test;
  import qlc_pkg::*;

  typedef enum logic [1:0] {
    ACT_TICK,
    ACT_GAIN,
    ACT_HOLD
  } act_kind_e;

  // One pending stimulus entry: a tick request, a gain write or a hold-off
  typedef struct {
    act_kind_e        kind;
    logic             req;
    logic [LANES-1:0] lines;
    logic [1:0]       gain;
  } act_t;

  typedef logic [LANES-1:0][WORD_W-1:0] chip_words_t;

  localparam int unsigned TOTAL_TICKS  = 1600;
  localparam int unsigned STALL_LIMIT  = 1000;
  localparam int unsigned DRAIN_CYCLES = 8;
  localparam int unsigned RESET_CYCLES = 12;

  logic clk;
  logic rst_n;

  qlc_in_if  in_ch ();
  qlc_out_if out_ch ();
  qlc_cfg_if cfg_ch ();

  quad_load_cell_adc_serial_reader_core u_top (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  act_t      pending[$];
  tick_res_t tick_expected[$];
  int        err_count = 0;

  // Sequencer mirror
  phase_t           seq_phase  = PH_IDLE;
  logic [CNT_W-1:0] seq_pulses = '0;
  logic             seq_clk_hi = 1'b0;
  word_t            seq_shift[LANES];
  word_t            seq_held[LANES];
  logic [1:0]       gain_reg   = GAIN_128;

  // Stimulus generation bookkeeping
  logic [1:0]  gen_gain  = GAIN_128;
  int unsigned gen_ticks = 0;

  // Sender burst shaping and receiver stall pattern
  int unsigned burst_left = 20;
  int unsigned gap_left   = 0;
  int unsigned rdy_mode   = 0;
  int unsigned rdy_cycle  = 0;
  int unsigned idle_run   = 0;

  initial begin
    for (int k = 0; k < LANES; k++) begin
      seq_shift[k] = '0;
      seq_held[k]  = '0;
    end
  end

  // Gain pulses after the data bits
  function automatic logic [CNT_W-1:0] pulse_tail(input logic [1:0] g);
    case (g)
      GAIN_64: return CNT_W'(3);
      GAIN_32: return CNT_W'(2);
      default: return CNT_W'(1);
    endcase
  endfunction

  // Advance the sequencer mirror by one tick and queue what it must produce
  task automatic tick_predict(input logic req, input logic [LANES-1:0] lines);
    tick_res_t        r;
    logic [LANES-1:0] act;
    act            = lines & ACTIVE_MASK;
    r.clock_out    = 1'b0;
    r.busy_res     = 1'b0;
    r.result_valid = 1'b0;
    case (seq_phase)
      PH_IDLE: begin
        if (req) begin
          seq_phase  = PH_WAIT;
          r.busy_res = 1'b1;
        end
      end
      PH_WAIT: begin
        r.busy_res = 1'b1;
        if (act == '0) begin
          seq_phase  = PH_SHIFT;
          seq_pulses = '0;
          seq_clk_hi = 1'b0;
          for (int k = 0; k < LANES; k++) seq_shift[k] = '0;
        end
      end
      PH_SHIFT: begin
        r.busy_res = 1'b1;
        if (!seq_clk_hi) begin
          // rising half: sample while data bits remain
          r.clock_out = 1'b1;
          seq_clk_hi  = 1'b1;
          if (seq_pulses < DATA_PULSES) begin
            for (int k = 0; k < LANES; k++)
              seq_shift[k] = {seq_shift[k][WORD_W-2:0], act[k]};
          end
        end else begin
          // falling half: count the pulse, finish once the total is reached
          seq_clk_hi = 1'b0;
          seq_pulses = seq_pulses + 1'b1;
          if (seq_pulses >= DATA_PULSES + pulse_tail(gain_reg)) begin
            for (int k = 0; k < LANES; k++)
              seq_held[k] = ACTIVE_MASK[k] ?
                {~seq_shift[k][WORD_W-1], seq_shift[k][WORD_W-2:0]} : '0;
            r.result_valid = 1'b1;
            seq_phase      = PH_IDLE;
            seq_pulses     = '0;
          end
        end
      end
      default: seq_phase = PH_IDLE;
    endcase
    for (int k = 0; k < LANES; k++) r.values[k] = seq_held[k];
    tick_expected.push_back(r);
  endtask

  task automatic field_check(input string tag, input word_t want, input word_t got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %h, actual %h", $time, tag, want, got);
      err_count++;
    end
  endtask

  // ---------------------------------------------------------------------------
  // Stimulus builders
  task automatic push_tick(input logic req, input logic [LANES-1:0] lines);
    act_t a;
    a.kind  = ACT_TICK;
    a.req   = req;
    a.lines = lines;
    a.gain  = GAIN_128;
    pending.push_back(a);
    gen_ticks++;
  endtask

  task automatic push_gain(input logic [1:0] g);
    act_t a;
    a.kind  = ACT_GAIN;
    a.req   = 1'b0;
    a.lines = '0;
    a.gain  = g;
    pending.push_back(a);
    if (g != GAIN_RSVD) gen_gain = g;
  endtask

  task automatic push_hold();
    act_t a;
    a.kind  = ACT_HOLD;
    a.req   = 1'b0;
    a.lines = '0;
    a.gain  = GAIN_128;
    pending.push_back(a);
  endtask

  function automatic word_t rand_word();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return {WORD_W{1'b1}};
      2:       return {1'b1, {(WORD_W-1){1'b0}}};
      3:       return {1'b0, {(WORD_W-1){1'b1}}};
      default: return word_t'($urandom);
    endcase
  endfunction

  function automatic logic rand_req();
    return ($urandom_range(0, 3) == 0);
  endfunction

  // From the all-low tick through the last pulse; a gain write may land mid-read
  task automatic read_body(input chip_words_t w, input int unsigned split_at,
                           input logic [1:0] split_gain);
    logic [LANES-1:0] bits;
    int unsigned      i;
    logic             done;
    push_tick(rand_req(), '0);
    i    = 0;
    done = 1'b0;
    while (!done) begin
      if (split_at != 0 && i == split_at) push_gain(split_gain);
      if (i < DATA_PULSES) begin
        for (int k = 0; k < LANES; k++) bits[k] = w[k][WORD_W-1-i];
      end else begin
        bits = LANES'($urandom);
      end
      push_tick(rand_req(), bits);
      push_tick(rand_req(), LANES'($urandom));
      i++;
      done = (i >= int'(DATA_PULSES) + int'(pulse_tail(gen_gain)));
    end
  endtask

  task automatic add_read(input chip_words_t w, input int unsigned nwait,
                          input int unsigned split_at, input logic [1:0] split_gain);
    push_tick(1'b1, LANES'($urandom));
    repeat (nwait) push_tick(rand_req(), LANES'($urandom_range(1, (1 << LANES) - 1)));
    read_body(w, split_at, split_gain);
  endtask

  // ---------------------------------------------------------------------------
  // Clock
  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Reset and known input levels from time zero
  initial begin
    rst_n              = 1'b0;
    in_ch.valid        = 1'b0;
    in_ch.read_request = 1'b0;
    in_ch.dout_lines   = '0;
    cfg_ch.valid       = 1'b0;
    cfg_ch.gain_select = GAIN_128;
    out_ch.ready       = 1'b0;
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
  end

  // Stimulus list, then the end-of-run check
  initial begin
    chip_words_t w;
    int unsigned pick;
    int unsigned n;
    int unsigned split_at;

    // idle ticks, no request
    push_tick(1'b0, 4'hF);
    push_tick(1'b0, 4'h0);
    // request, then each line alone holding the read off
    push_tick(1'b1, 4'hF);
    push_tick(1'b1, 4'h1);
    push_tick(1'b0, 4'h2);
    push_tick(1'b1, 4'h4);
    push_tick(1'b0, 4'h8);
    w = {24'h7FFFFF, 24'h800000, 24'h000000, 24'hFFFFFF};
    read_body(w, 0, GAIN_128);
    // each gain code, reserved code ignored
    push_gain(GAIN_64);
    w = {24'hFFFFFE, 24'h000001, 24'h555555, 24'hAAAAAA};
    add_read(w, 1, 0, GAIN_128);
    push_gain(GAIN_RSVD);
    w = {rand_word(), rand_word(), rand_word(), rand_word()};
    add_read(w, 0, 0, GAIN_128);
    push_gain(GAIN_32);
    w = {rand_word(), rand_word(), rand_word(), rand_word()};
    add_read(w, 2, 0, GAIN_128);
    // gain 128 selected mid-read after the count already passed the new, lower total
    push_gain(GAIN_64);
    w = {rand_word(), rand_word(), rand_word(), rand_word()};
    add_read(w, 0, 26, GAIN_128);
    // gain 64 selected mid-read during the data bits, raising the pulse total
    w = {rand_word(), rand_word(), rand_word(), rand_word()};
    add_read(w, 1, 10, GAIN_64);
    // reserved code mid-read
    push_gain(GAIN_32);
    w = {rand_word(), rand_word(), rand_word(), rand_word()};
    add_read(w, 0, 25, GAIN_RSVD);
    push_hold();
    push_tick(1'b0, 4'h0);

    // random part: mostly well-formed reads, some noise
    while (gen_ticks < TOTAL_TICKS) begin
      pick = $urandom_range(0, 99);
      if (pick < 6) begin
        n = $urandom_range(10, 40);
        repeat (n) push_tick(rand_req(), LANES'($urandom));
        // quiet lines let any read in progress run out
        repeat (60) push_tick(1'b0, '0);
      end else if (pick < 14) begin
        push_gain(2'($urandom_range(0, 3)));
      end else if (pick < 17) begin
        push_hold();
      end else begin
        w        = {rand_word(), rand_word(), rand_word(), rand_word()};
        split_at = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 27) : 0;
        add_read(w, ($urandom_range(0, 2) == 0) ? $urandom_range(1, 4) : 0,
                 split_at, 2'($urandom_range(0, 3)));
      end
      n = $urandom_range(0, 3);
      repeat (n) push_tick(1'b0, LANES'($urandom));
    end

    @(posedge clk);
    while (!rst_n) @(posedge clk);
    while (pending.size() != 0 || tick_expected.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (err_count == 0 && tick_expected.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Driver: tick requests in bursts, gain writes only with nothing outstanding
  always @(posedge clk) begin
    logic             nxt_valid;
    logic             nxt_req;
    logic [LANES-1:0] nxt_lines;
    logic             nxt_cfg_valid;
    logic [1:0]       nxt_gain;
    if (!rst_n) begin
      in_ch.valid  <= 1'b0;
      cfg_ch.valid <= 1'b0;
    end else begin
      nxt_valid     = in_ch.valid;
      nxt_req       = in_ch.read_request;
      nxt_lines     = in_ch.dout_lines;
      nxt_cfg_valid = cfg_ch.valid;
      nxt_gain      = cfg_ch.gain_select;

      if (in_ch.valid && in_ch.ready) begin
        tick_predict(in_ch.read_request, in_ch.dout_lines);
        void'(pending.pop_front());
        nxt_valid = 1'b0;
        if (burst_left > 0) burst_left--;
        if (burst_left == 0) begin
          burst_left = $urandom_range(1, 30);
          gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
        end
      end

      if (cfg_ch.valid && cfg_ch.ready) begin
        if (cfg_ch.gain_select != GAIN_RSVD) gain_reg = cfg_ch.gain_select;
        void'(pending.pop_front());
        nxt_cfg_valid = 1'b0;
      end

      // pick up the next entry once nothing is in flight on either channel
      if (!nxt_valid && !nxt_cfg_valid) begin
        if (gap_left > 0) begin
          gap_left--;
        end else if (pending.size() > 0) begin
          case (pending[0].kind)
            ACT_TICK: begin
              nxt_valid = 1'b1;
              nxt_req   = pending[0].req;
              nxt_lines = pending[0].lines;
            end
            ACT_GAIN: begin
              if (tick_expected.size() == 0) begin
                nxt_cfg_valid = 1'b1;
                nxt_gain      = pending[0].gain;
              end
            end
            default: begin
              if (tick_expected.size() == 0) void'(pending.pop_front());
            end
          endcase
        end
      end

      in_ch.valid        <= nxt_valid;
      in_ch.read_request <= nxt_req;
      in_ch.dout_lines   <= nxt_lines;
      cfg_ch.valid       <= nxt_cfg_valid;
      cfg_ch.gain_select <= nxt_gain;
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: check each result request against the oldest prediction
  always @(posedge clk) begin
    tick_res_t want;
    logic      rdy;
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (tick_expected.size() == 0) begin
          $display("%0t: result with nothing expected, actual clk %b busy %b valid %b",
                   $time, out_ch.clock_out, out_ch.busy_res, out_ch.result_valid);
          err_count++;
        end else begin
          want = tick_expected.pop_front();
          field_check("clock_out", word_t'(want.clock_out), word_t'(out_ch.clock_out));
          field_check("busy_res", word_t'(want.busy_res), word_t'(out_ch.busy_res));
          field_check("result_valid", word_t'(want.result_valid),
                      word_t'(out_ch.result_valid));
          field_check("value_chip0", want.values[0], out_ch.value_chip0);
          field_check("value_chip1", want.values[1], out_ch.value_chip1);
          field_check("value_chip2", want.values[2], out_ch.value_chip2);
          field_check("value_chip3", want.values[3], out_ch.value_chip3);
        end
      end

      // receiver stall pattern, with a randomly chosen mode
      rdy_cycle++;
      if (rdy_cycle % 300 == 0) rdy_mode = $urandom_range(0, 3);
      case (rdy_mode)
        0:       rdy = 1'b1;
        1:       rdy = $urandom_range(0, 1);
        2:       rdy = (rdy_cycle % 3 == 0);
        default: rdy = ($urandom_range(0, 7) == 0);
      endcase
      out_ch.ready <= rdy;
    end
  end

  // Watchdog: too long without any request accepted
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
          (cfg_ch.valid && cfg_ch.ready)) begin
        idle_run <= 0;
      end else if (idle_run >= STALL_LIMIT) begin
        $display("Some tests failed");
        $finish;
      end else begin
        idle_run <= idle_run + 1;
      end
    end
  end

endmodule
